/* rtl/lspd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lspd_pkg
// shared types and constants of the watch stepper pulse driver
// ----------------------------------------------------------------------------
package lspd_pkg;

    localparam int unsigned POS_W     = 9;
    localparam int unsigned TICK_W    = 16;
    localparam int unsigned STEP_W    = 10;
    localparam int unsigned PADDR_W   = 4;
    localparam int unsigned PDATA_W   = 32;

    localparam logic [POS_W-1:0]  FULL_TURN       = POS_W'(360);
    localparam logic [POS_W-1:0]  PPT_RESET       = POS_W'(180);
    localparam logic [TICK_W-1:0] ON_TICKS_RESET  = TICK_W'(10);
    localparam logic [TICK_W-1:0] OFF_TICKS_RESET = TICK_W'(10);

    // register indexes
    localparam logic [1:0] REG_PPT       = 2'd0;
    localparam logic [1:0] REG_ON_TICKS  = 2'd1;
    localparam logic [1:0] REG_OFF_TICKS = 2'd2;

    // opcodes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_MOVE  = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;

    // phase codes as seen on the result word
    localparam logic [1:0] PHASE_INIT = 2'd0;
    localparam logic [1:0] PHASE_WAIT = 2'd1;
    localparam logic [1:0] PHASE_ON   = 2'd2;
    localparam logic [1:0] PHASE_OFF  = 2'd3;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [STEP_W-1:0] step_count;
        logic              turn_clockwise;
    } in_word_t;

    typedef struct packed {
        logic              pin_a_level;
        logic              pin_b_level;
        logic              pin_c_level;
        logic              pin_a_floating;
        logic              pin_b_floating;
        logic [POS_W-1:0]  hand_position;
        logic [1:0]        phase;
        logic [STEP_W-1:0] steps_remaining;
    } out_word_t;

    typedef struct packed {
        logic [POS_W-1:0]  positions_per_turn;
        logic [TICK_W-1:0] on_ticks;
        logic [TICK_W-1:0] off_ticks;
    } cfg_t;

    typedef struct packed {
        logic pin_a;
        logic pin_b;
        logic pin_c;
        logic float_a;
        logic float_b;
    } pins_t;

endpackage

/* rtl/lspd_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lspd_regs
// apb configuration registers: positions per turn, on and off tick counts
// ----------------------------------------------------------------------------
module lspd_regs import lspd_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.positions_per_turn <= PPT_RESET;
            cfg_reg.on_ticks           <= ON_TICKS_RESET;
            cfg_reg.off_ticks          <= OFF_TICKS_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_PPT:       cfg_reg.positions_per_turn <= pwdata[POS_W-1:0];
                REG_ON_TICKS:  cfg_reg.on_ticks           <= pwdata[TICK_W-1:0];
                REG_OFF_TICKS: cfg_reg.off_ticks          <= pwdata[TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_PPT:       prdata = PDATA_W'(cfg_reg.positions_per_turn);
            REG_ON_TICKS:  prdata = PDATA_W'(cfg_reg.on_ticks);
            REG_OFF_TICKS: prdata = PDATA_W'(cfg_reg.off_ticks);
            default:       prdata = '0;
        endcase
    end

endmodule

/* rtl/lspd_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lspd_core
// phase sequencer, step counter, hand position and pin drive for one word
// ----------------------------------------------------------------------------
module lspd_core import lspd_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  cfg_t      cfg,
    input  logic      in_en,
    input  in_word_t  in_word,
    output out_word_t res_word
);

    typedef enum logic [1:0] {
        ST_INIT = PHASE_INIT,
        ST_WAIT = PHASE_WAIT,
        ST_ON   = PHASE_ON,
        ST_OFF  = PHASE_OFF
    } phase_t;

    phase_t             phase_reg,     phase_next;
    logic [STEP_W-1:0]  steps_reg,     steps_next;
    logic [POS_W-1:0]   position_reg,  position_next;
    logic               polarity_reg,  polarity_next;
    logic               direction_reg, direction_next;
    logic [TICK_W-1:0]  timer_reg,     timer_next;
    pins_t              pins_reg,      pins_next;

    logic [POS_W-1:0]   turn_last;
    logic [TICK_W-1:0]  on_len;
    logic [TICK_W-1:0]  off_len;
    logic               do_pulse;
    logic [POS_W-1:0]   pos_step;

    always_comb begin
        if (cfg.positions_per_turn == '0) begin
            turn_last = '0;
        end else if (cfg.positions_per_turn > FULL_TURN) begin
            turn_last = FULL_TURN - POS_W'(1);
        end else begin
            turn_last = cfg.positions_per_turn - POS_W'(1);
        end
    end

    assign on_len  = (cfg.on_ticks  == '0) ? TICK_W'(1) : cfg.on_ticks;
    assign off_len = (cfg.off_ticks == '0) ? TICK_W'(1) : cfg.off_ticks;

    always_comb begin
        phase_next     = phase_reg;
        steps_next     = steps_reg;
        position_next  = position_reg;
        polarity_next  = polarity_reg;
        direction_next = direction_reg;
        timer_next     = timer_reg;
        pins_next      = pins_reg;
        do_pulse       = 1'b0;

        case (in_word.opcode)
            OP_START: begin
                if (phase_reg == ST_INIT) begin
                    phase_next = ST_WAIT;
                end
            end
            OP_MOVE: begin
                if (phase_reg == ST_WAIT) begin
                    steps_next     = in_word.step_count;
                    direction_next = in_word.turn_clockwise;
                    do_pulse       = (in_word.step_count != '0);
                end
            end
            OP_TICK: begin
                if (phase_reg == ST_ON || phase_reg == ST_OFF) begin
                    if (timer_reg > TICK_W'(1)) begin
                        timer_next = timer_reg - TICK_W'(1);
                    end else if (phase_reg == ST_ON) begin
                        pins_next  = '0;
                        timer_next = off_len;
                        phase_next = ST_OFF;
                    end else if (steps_reg != '0) begin
                        do_pulse = 1'b1;
                    end else begin
                        timer_next = '0;
                        phase_next = ST_WAIT;
                    end
                end
            end
            default: begin
            end
        endcase

        // shared step start
        if (direction_next) begin
            pos_step = (position_reg >= turn_last) ? '0 : position_reg + POS_W'(1);
        end else begin
            pos_step = (position_reg == '0 || position_reg > turn_last) ?
                       turn_last : position_reg - POS_W'(1);
        end

        if (do_pulse) begin
            steps_next    = steps_next - STEP_W'(1);
            position_next = pos_step;
            pins_next     = '0;
            if (direction_next) begin
                pins_next.float_b = 1'b1;
                pins_next.pin_a   = polarity_reg;
            end else begin
                pins_next.float_a = 1'b1;
                pins_next.pin_b   = polarity_reg;
            end
            pins_next.pin_c = ~polarity_reg;
            polarity_next   = ~polarity_reg;
            timer_next      = on_len;
            phase_next      = ST_ON;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= ST_INIT;
            steps_reg     <= '0;
            position_reg  <= '0;
            polarity_reg  <= 1'b1;
            direction_reg <= 1'b0;
            timer_reg     <= '0;
            pins_reg      <= '0;
        end else if (in_en) begin
            phase_reg     <= phase_next;
            steps_reg     <= steps_next;
            position_reg  <= position_next;
            polarity_reg  <= polarity_next;
            direction_reg <= direction_next;
            timer_reg     <= timer_next;
            pins_reg      <= pins_next;
        end
    end

    assign res_word.pin_a_level     = pins_next.pin_a;
    assign res_word.pin_b_level     = pins_next.pin_b;
    assign res_word.pin_c_level     = pins_next.pin_c;
    assign res_word.pin_a_floating  = pins_next.float_a;
    assign res_word.pin_b_floating  = pins_next.float_b;
    assign res_word.hand_position   = position_next;
    assign res_word.phase           = 2'(phase_next);
    assign res_word.steps_remaining = steps_next;

endmodule

/* rtl/lspd_out_buf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lspd_out_buf
// result register with skid stage; input ready drops only when the skid is full
// ----------------------------------------------------------------------------
module lspd_out_buf import lspd_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_en,
    input  out_word_t in_word,
    output logic      in_ready,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_word
);

    logic      main_valid_reg;
    logic      skid_valid_reg;
    out_word_t main_word_reg;
    out_word_t skid_word_reg;

    assign in_ready = ~skid_valid_reg;
    assign m_valid  = main_valid_reg;
    assign m_word   = main_word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_ready || !main_valid_reg) begin
            main_valid_reg <= skid_valid_reg | in_en;
            skid_valid_reg <= 1'b0;
        end else if (in_en) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_ready || !main_valid_reg) begin
            main_word_reg <= skid_valid_reg ? skid_word_reg : in_word;
        end else if (in_en) begin
            skid_word_reg <= in_word;
        end
    end

endmodule

/* rtl/lavet_stepper_pulse_driver.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lavet_stepper_pulse_driver
// three-pin pulse driver for a watch-hand stepper
//
// s_ channel takes one word per item: a tick, a move request or a start.
// m_ channel returns exactly one word per item with the pin drive, hand
// position, phase and steps left after that item.
// apb port holds positions per turn and the on and off tick counts; write
// only while no word is in flight.
// the result word is registered in the output buffer before it is on m_.
// throughput: one item per cycle while s_ready is high, set by the single
// state update between the state registers and the result register.
// a skid stage holds one more word while m_ready is low; s_ready then drops
// until the receiver takes a word.
// reset: registers return to 180 / 10 / 10, phase goes to init, hand to 0,
// pins all driven low, no word pending.
// ----------------------------------------------------------------------------
module lavet_stepper_pulse_driver import lspd_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  in_word_t           s_word,
    output logic               m_valid,
    input  logic               m_ready,
    output out_word_t          m_word,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    cfg_t      cfg;
    logic      accept;
    out_word_t res_word;

    assign accept = s_valid & s_ready;

    lspd_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lspd_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .in_en    (accept),
        .in_word  (s_word),
        .res_word (res_word)
    );

    lspd_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_en    (accept),
        .in_word  (res_word),
        .in_ready (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_word   (m_word)
    );

    // a pulse floats exactly one coil pin
    a_on_one_float: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_word.phase == PHASE_ON |->
            $onehot({m_word.pin_a_floating, m_word.pin_b_floating}))
        else $error("pulse word does not float exactly one pin");

    // outside a pulse every pin is driven low
    a_idle_low: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_word.phase != PHASE_ON |->
            !(m_word.pin_a_level || m_word.pin_b_level || m_word.pin_c_level ||
              m_word.pin_a_floating || m_word.pin_b_floating))
        else $error("pins not low outside pulse");

    // the driven coil pin and C are opposite during a pulse
    a_on_opposite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_word.phase == PHASE_ON |->
            ((m_word.pin_a_level | m_word.pin_b_level) != m_word.pin_c_level))
        else $error("coil and common pin not opposite");

    // a full skid stage implies a pending result word
    a_skid_main: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("skid word without result word");

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_word.hand_position < FULL_TURN)
        else $error("hand position beyond a full turn");

endmodule
